// ----- rtl/counting_sort_engine_unit_defines.svh -----
// ----------------------------------------------------------------------------
// counting_sort_engine_unit_defines.svh
// Assertion macros used by the counting sort engine unit.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SORT_ENGINE_UNIT_DEFINES_SVH
`define COUNTING_SORT_ENGINE_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define CSE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("counting sort engine check failed");

// condition that must hold on every clock edge outside reset
`define CSE_ASSERT_ALWAYS(label, clk, rstn, cond) \
    `CSE_ASSERT_IMP(label, clk, rstn, 1'b1, cond)

`endif

// ----- rtl/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg
// Widths and types shared by the counting sort engine.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int VALUE_W = 16;
    localparam int COUNT_W = 7;
    localparam int KEPT_W  = 7;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [VALUE_W-1:0] value_t;

endpackage

// ----- rtl/cse_count_ram.sv -----
// ----------------------------------------------------------------------------
// cse_count_ram
// Bucket count store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cse_count_ram
    import cse_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  count_t        wdata,
    input  logic [AW-1:0] raddr,
    output count_t        rdata
);

    count_t mem [DEPTH];
    count_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/counting_sort_engine_unit.sv -----
// ----------------------------------------------------------------------------
// counting_sort_engine_unit
// Counting sort over the window [min_value, min_value+BUCKETS-1].
//
//  channel   signals                                   handshake
//  command   start, value, last_item                   start & !busy
//  config    cfg_valid, cfg_data                       cfg_valid & cfg_ready
//  result    res_valid, sorted_value, last,            res_valid, one cycle
//            empty_res, overflow
//
// A kept value takes a count read and a count write; a dropped one no write.
// The marked beat then scans buckets from zero (read, check), emitting one
// result per kept item and stopping at the final result; busy stays high.
// After reset a clearing pass over all BUCKETS entries holds busy high.
// Results cannot be stalled; each stands for exactly one cycle.
// ----------------------------------------------------------------------------
`include "counting_sort_engine_unit_defines.svh"

module counting_sort_engine_unit
    import cse_pkg::*;
#(
    parameter int BUCKETS   = 256,
    parameter int MAX_ITEMS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] value,
    input  logic               last_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [15:0] cfg_data,
    output logic               res_valid,
    output logic signed [15:0] sorted_value,
    output logic               last,
    output logic               empty_res,
    output logic               overflow
);

    localparam int BW = $clog2(BUCKETS);
    localparam logic [BW-1:0]     LAST_IDX = BW'(BUCKETS - 1);
    localparam logic [KEPT_W-1:0] MAX_K    = KEPT_W'(MAX_ITEMS);
    localparam logic [16:0]       BUCKETS_W = 17'(BUCKETS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT
    } state_t;

    state_t            state_reg;
    value_t            min_reg;
    logic [BW-1:0]     idx_reg;
    logic [KEPT_W-1:0] kept_reg;
    logic [KEPT_W-1:0] rem_reg;
    count_t            cnt_reg;
    logic              dropped_reg;
    logic              last_pend_reg;
    logic              res_valid_reg;
    value_t            sorted_reg;
    logic              last_reg;
    logic              empty_reg;
    logic              overflow_reg;

    logic [16:0]   off;
    logic          in_win;
    logic          hit;
    logic          accept;
    logic          ram_we;
    logic [BW-1:0] ram_waddr;
    count_t        ram_wdata;
    logic [BW-1:0] ram_raddr;
    count_t        ram_rdata;

    assign off    = {value[15], value} - {min_reg[15], min_reg};
    assign in_win = !off[16] && (off < BUCKETS_W);
    assign hit    = in_win && (kept_reg < MAX_K);
    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        ram_raddr = idx_reg;
        unique case (state_reg)
            S_CLEAR:    ram_we = 1'b1;
            S_IDLE:     ram_raddr = off[BW-1:0];
            S_INC:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata + COUNT_W'(1);
            end
            S_SCAN_RD:  ram_we = 1'b0;
            S_SCAN_CHK: ram_we = (ram_rdata != '0);
            S_EMIT:     ram_we = 1'b0;
            default:    ram_we = 1'b0;
        endcase
    end

    cse_count_ram #(
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            min_reg       <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            dropped_reg   <= 1'b0;
            last_pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            sorted_reg    <= '0;
            last_reg      <= 1'b0;
            empty_reg     <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                min_reg <= cfg_data;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + BW'(1);
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_pend_reg <= last_item;
                        if (hit)
                        begin
                            idx_reg   <= off[BW-1:0];
                            kept_reg  <= kept_reg + KEPT_W'(1);
                            state_reg <= S_INC;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                            if (last_item)
                            begin
                                if (kept_reg == '0)
                                begin
                                    res_valid_reg <= 1'b1;
                                    sorted_reg    <= '0;
                                    last_reg      <= 1'b1;
                                    empty_reg     <= 1'b1;
                                    overflow_reg  <= 1'b1;
                                    dropped_reg   <= 1'b0;
                                end
                                else
                                begin
                                    idx_reg   <= '0;
                                    rem_reg   <= kept_reg;
                                    state_reg <= S_SCAN_RD;
                                end
                            end
                        end
                    end
                end
                S_INC:
                begin
                    if (last_pend_reg)
                    begin
                        idx_reg   <= '0;
                        rem_reg   <= kept_reg;
                        state_reg <= S_SCAN_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    if (ram_rdata == '0)
                    begin
                        idx_reg   <= idx_reg + BW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                    else
                    begin
                        cnt_reg   <= ram_rdata;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    res_valid_reg <= 1'b1;
                    sorted_reg    <= min_reg + VALUE_W'(idx_reg);
                    last_reg      <= (rem_reg == KEPT_W'(1));
                    empty_reg     <= 1'b0;
                    overflow_reg  <= (rem_reg == KEPT_W'(1)) && dropped_reg;
                    rem_reg       <= rem_reg - KEPT_W'(1);
                    cnt_reg       <= cnt_reg - COUNT_W'(1);
                    if (rem_reg == KEPT_W'(1))
                    begin
                        kept_reg    <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                    else if (cnt_reg == COUNT_W'(1))
                    begin
                        idx_reg   <= idx_reg + BW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign res_valid    = res_valid_reg;
    assign sorted_value = sorted_reg;
    assign last         = last_reg;
    assign empty_res    = empty_reg;
    assign overflow     = overflow_reg;

    `CSE_ASSERT_IMP(a_final_frees, clk, rst_n, res_valid && last, !busy)
    `CSE_ASSERT_IMP(a_empty_final, clk, rst_n, res_valid && empty_res, last)
    `CSE_ASSERT_IMP(a_ovf_final, clk, rst_n, res_valid && overflow, last)
    `CSE_ASSERT_ALWAYS(a_kept_cap, clk, rst_n, kept_reg <= MAX_K)
    `CSE_ASSERT_IMP(a_emit_left, clk, rst_n, state_reg == S_EMIT, rem_reg != '0)

endmodule
